// File: sv/csl_pkg.sv
package csl_pkg;

   typedef enum logic [1:0] {
      LM_IDLE    = 2'd0,
      LM_NUMBER  = 2'd1,
      LM_IDENT   = 2'd2,
      LM_COMMENT = 2'd3
   } lexer_mode_type;

   typedef enum logic [3:0] {
      TC_INTEGER    = 4'd0,
      TC_DECIMAL    = 4'd1,
      TC_KEYWORD    = 4'd2,
      TC_IDENT      = 4'd3,
      TC_SEPARATOR  = 4'd4,
      TC_OPERATOR   = 4'd5,
      TC_COMPARATOR = 4'd6,
      TC_COMMENT    = 4'd7,
      TC_ERROR      = 4'd8
   } token_class_type;

   typedef struct packed {
      logic [7:0] char_code;
   } csl_req_type;

   typedef struct packed {
      logic [3:0]  token_class;
      logic [15:0] token_start;
      logic [7:0]  token_length;
      logic [7:0]  token_char;
      logic [3:0]  keyword_index;
      logic        last_of_run;
   } csl_rsp_type;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;

   localparam int KW_COUNT     = 15;
   localparam int KW_MAX_CHARS = 8;
   localparam int KW_BITS      = 8 * KW_MAX_CHARS;

   typedef logic [KW_MAX_CHARS-1:0][7:0] kw_prefix_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] index;
   } kw_match_type;

   // text is left aligned: first char in the top byte
   localparam logic [7:0] KW_LEN [KW_COUNT] = '{
      8'd6, 8'd5, 8'd4, 8'd7, 8'd3, 8'd3, 8'd3, 8'd5,
      8'd2, 8'd2, 8'd5, 8'd8, 8'd3, 8'd3, 8'd3
   };

   localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      {8'h4A, 8'h41, 8'h52, 8'h56, 8'h49, 8'h53, 16'h0},
      {"clase", 24'h0},
      {"modo", 32'h0},
      {"abierto", 8'h0},
      {"ent", 40'h0},
      {"cad", 40'h0},
      {"imp", 40'h0},
      {"bucle", 24'h0},
      {"si", 48'h0},
      {"no", 48'h0},
      {"hacer", 24'h0},
      {"mientras"},
      {"est", 40'h0},
      {"car", 40'h0},
      {"num", 40'h0}
   };

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_sep(logic [7:0] c);
      return c == " " || c == "{" || c == "(" || c == ")" || c == "}" ||
             c == ";" || c == ":" || c == 8'd10 || c == 8'd9;
   endfunction

   function automatic logic is_op(logic [7:0] c);
      return c == "=" || c == "+" || c == "-" || c == "%" || c == "*";
   endfunction

   function automatic logic is_cmp(logic [7:0] c);
      return c == CH_LT || c == CH_GT;
   endfunction

   function automatic kw_match_type kw_lookup(kw_prefix_type pre, logic [7:0] len);
      kw_match_type m;
      logic         same;
      m = '0;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         same = (len == KW_LEN[i]);
         for (int j = 0; j < KW_MAX_CHARS; j++) begin
            if (j < int'(KW_LEN[i]) && pre[j] != KW_TEXT[i][KW_BITS-1-8*j -: 8]) begin
               same = 1'b0;
            end
         end
         if (same) begin
            m.hit   = 1'b1;
            m.index = 4'(i);
         end
      end
      return m;
   endfunction

   function automatic csl_rsp_type make_token(token_class_type cls, logic [15:0] start,
                                              logic [7:0] len, logic [7:0] ch,
                                              logic [3:0] kw);
      csl_rsp_type t;
      t.token_class   = cls;
      t.token_start   = start;
      t.token_length  = len;
      t.token_char    = ch;
      t.keyword_index = kw;
      t.last_of_run   = 1'b0;
      return t;
   endfunction

endpackage

// File: sv/csl_stream_if.sv
interface csl_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: sv/char_stream_lexer.sv
// channel   dir  word          handshake
// req_port  in   char_code     valid/ready
// rsp_port  out  token fields  valid/ready
//
// One character per cycle while the queue has room: input register,
// combinational lexer logic, then a 4-word result queue. A character closing
// a number or identifier on a delimiter pushes two words into the queue.
// The lexer stage advances only while the queue has room for two words.
// Reset is synchronous; it clears mode, run counters, position and queue.
module char_stream_lexer import csl_pkg::*; #(
   parameter int KEYWORD_CHARS  = 8,
   parameter int MAX_RUN_LENGTH = 255
) (
   input  logic         clock,
   input  logic         reset,
   csl_stream_if.sink   req_port,
   csl_stream_if.source rsp_port
);

   localparam int LenLimit  = (MAX_RUN_LENGTH < 255) ? MAX_RUN_LENGTH : 255;
   localparam int IdxW      = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;
   localparam int FifoDepth = 4;
   localparam int PtrW      = $clog2(FifoDepth);
   localparam int CntW      = PtrW + 1;

   logic                 in_valid_ff;
   logic [7:0]           in_char_ff;
   lexer_mode_type       mode_ff, mode_in;
   logic [7:0]           prefix_ff [KEYWORD_CHARS];
   logic [7:0]           run_length_ff, run_length_in;
   logic                 fraction_ff, fraction_in;
   logic [15:0]          run_start_ff, run_start_in;
   logic [15:0]          char_pos_ff, char_pos_in;
   csl_rsp_type          fifo_ff [FifoDepth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;

   logic                 req_fire;
   logic                 pop;
   logic                 proc;
   logic [CntW-1:0]      occ;
   logic [1:0]           n_res;
   csl_rsp_type          res0, res1;
   logic                 pre_we;
   logic [IdxW-1:0]      pre_waddr;
   logic                 do_append;
   logic                 do_start;
   logic                 emit_comment;
   logic [7:0]           base_len;
   kw_prefix_type        prefix_word;
   kw_match_type         kw;

   assign pop       = rsp_port.valid && rsp_port.ready;
   assign occ       = count_ff - CntW'(pop);
   assign proc      = in_valid_ff && (occ <= CntW'(FifoDepth - 2));
   assign req_port.ready = !in_valid_ff || proc;
   assign req_fire  = req_port.valid && req_port.ready;

   assign rsp_port.valid   = (count_ff != '0);
   assign rsp_port.payload = fifo_ff[rd_ptr_ff];

   always_comb begin
      for (int j = 0; j < KW_MAX_CHARS; j++) begin
         prefix_word[j] = prefix_ff[j];
      end
   end

   assign kw = kw_lookup(prefix_word, run_length_ff);

   always_comb begin
      mode_in       = mode_ff;
      run_length_in = run_length_ff;
      fraction_in   = fraction_ff;
      run_start_in  = run_start_ff;
      char_pos_in   = char_pos_ff;
      n_res         = 2'd0;
      res0          = '0;
      res1          = '0;
      do_append     = 1'b0;
      do_start      = 1'b0;
      emit_comment  = 1'b0;
      pre_we        = 1'b0;
      if (proc) begin
         char_pos_in = char_pos_ff + 16'd1;
         case (mode_ff)
            LM_NUMBER: begin
               if (is_digit(in_char_ff)) begin
                  do_append = 1'b1;
               end else if (in_char_ff == CH_DOT) begin
                  fraction_in = 1'b1;
                  do_append   = 1'b1;
               end else if (is_op(in_char_ff) || is_sep(in_char_ff)) begin
                  res0 = make_token(fraction_ff ? TC_DECIMAL : TC_INTEGER, run_start_ff,
                                    run_length_ff, 8'd0, 4'd0);
                  res1 = make_token(is_op(in_char_ff) ? TC_OPERATOR : TC_SEPARATOR,
                                    char_pos_ff, 8'd1, in_char_ff, 4'd0);
                  n_res   = 2'd2;
                  mode_in = LM_IDLE;
               end else begin
                  res0  = make_token(TC_ERROR, char_pos_ff, 8'd1, in_char_ff, 4'd0);
                  n_res = 2'd1;
               end
            end
            LM_IDENT: begin
               if (is_letter(in_char_ff) || is_digit(in_char_ff)) begin
                  do_append = 1'b1;
               end else if (is_op(in_char_ff) || is_cmp(in_char_ff) ||
                            is_sep(in_char_ff)) begin
                  res0 = make_token(kw.hit ? TC_KEYWORD : TC_IDENT, run_start_ff,
                                    run_length_ff, 8'd0, kw.hit ? kw.index : 4'd0);
                  res1 = make_token(is_op(in_char_ff) ? TC_OPERATOR :
                                    (is_cmp(in_char_ff) ? TC_COMPARATOR : TC_SEPARATOR),
                                    char_pos_ff, 8'd1, in_char_ff, 4'd0);
                  n_res   = 2'd2;
                  mode_in = LM_IDLE;
               end else begin
                  res0  = make_token(TC_ERROR, char_pos_ff, 8'd1, in_char_ff, 4'd0);
                  n_res = 2'd1;
               end
            end
            LM_COMMENT: begin
               do_append = 1'b1;
               if (in_char_ff == CH_SLASH) begin
                  emit_comment = 1'b1;
                  mode_in      = LM_IDLE;
               end
            end
            default: begin
               if (is_letter(in_char_ff)) begin
                  do_start  = 1'b1;
                  do_append = 1'b1;
                  mode_in   = LM_IDENT;
               end else if (is_digit(in_char_ff)) begin
                  do_start  = 1'b1;
                  do_append = 1'b1;
                  mode_in   = LM_NUMBER;
               end else if (is_space(in_char_ff) || is_sep(in_char_ff)) begin
                  res0  = make_token(TC_SEPARATOR, char_pos_ff, 8'd1, in_char_ff, 4'd0);
                  n_res = 2'd1;
               end else if (is_op(in_char_ff)) begin
                  res0  = make_token(TC_OPERATOR, char_pos_ff, 8'd1, in_char_ff, 4'd0);
                  n_res = 2'd1;
               end else if (is_cmp(in_char_ff)) begin
                  res0  = make_token(TC_COMPARATOR, char_pos_ff, 8'd1, in_char_ff, 4'd0);
                  n_res = 2'd1;
               end else if (in_char_ff == CH_SLASH) begin
                  do_start  = 1'b1;
                  do_append = 1'b1;
                  mode_in   = LM_COMMENT;
               end
            end
         endcase
      end

      if (do_start) begin
         run_start_in = char_pos_ff;
         fraction_in  = 1'b0;
      end
      base_len  = do_start ? 8'd0 : run_length_ff;
      pre_waddr = base_len[IdxW-1:0];
      if (do_append) begin
         run_length_in = base_len;
         if (int'(base_len) < KEYWORD_CHARS) begin
            pre_we = 1'b1;
         end
         if (int'(base_len) < LenLimit) begin
            run_length_in = base_len + 8'd1;
         end
      end

      // comment length includes the closing slash
      if (emit_comment) begin
         res0  = make_token(TC_COMMENT, run_start_ff, run_length_in, 8'd0, 4'd0);
         n_res = 2'd1;
      end

      if (n_res == 2'd1) begin
         res0.last_of_run = 1'b1;
      end
      if (n_res == 2'd2) begin
         res1.last_of_run = 1'b1;
      end
   end

   assign wr_ptr_in = wr_ptr_ff + PtrW'(n_res);
   assign rd_ptr_in = rd_ptr_ff + PtrW'(pop);
   assign count_in  = count_ff - CntW'(pop) + CntW'(n_res);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mode_ff       <= LM_IDLE;
         run_length_ff <= 8'd0;
         fraction_ff   <= 1'b0;
         run_start_ff  <= 16'd0;
         char_pos_ff   <= 16'd0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (proc) begin
            in_valid_ff <= 1'b0;
         end
         mode_ff       <= mode_in;
         run_length_ff <= run_length_in;
         fraction_ff   <= fraction_in;
         run_start_ff  <= run_start_in;
         char_pos_ff   <= char_pos_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_port.payload.char_code;
      end
      if (pre_we) begin
         prefix_ff[pre_waddr] <= in_char_ff;
      end
      if (n_res != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         fifo_ff[wr_ptr_ff + PtrW'(1)] <= res1;
      end
   end

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(FifoDepth))
      else $error("result queue overflow");

   a_pair_closes_run: assert property (@(posedge clock) disable iff (reset)
      n_res == 2'd2 |-> (mode_ff == LM_NUMBER || mode_ff == LM_IDENT) && mode_in == LM_IDLE)
      else $error("two words without a closing run");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      mode_ff != LM_IDLE |-> run_length_ff != 8'd0)
      else $error("open run with zero length");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc |=> in_valid_ff && $stable(in_char_ff))
      else $error("stalled character lost");

   a_idle_queue: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 && !proc |=> count_ff == '0)
      else $error("word appeared without a character");
`endif

endmodule
